@@ sv/ihau_pkg.sv @@
package ihau_pkg;

   // Sizes of the bin store
   localparam int NUM_BINS_DEF = 128;
   localparam int COUNT_W      = 31;
   localparam int TAG_W        = 8;
   localparam int LEN_OUT_W    = 8;

   localparam logic [COUNT_W-1:0]   COUNT_MAX   = {COUNT_W{1'b1}};
   localparam logic [LEN_OUT_W-1:0] LEN_OUT_MAX = {LEN_OUT_W{1'b1}};

   // Operation codes carried in the op field
   typedef enum logic [1:0] {
      OP_COUNT = 2'd0,
      OP_READ  = 2'd1,
      OP_CLEAR = 2'd2
   } op_type;

   // Tag sweep control
   typedef enum logic {
      ST_SWEEP = 1'b0,
      ST_RUN   = 1'b1
   } sweep_state_type;

   typedef struct packed {
      logic [1:0]         op;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic [COUNT_W-1:0]   bin_count;
      logic [LEN_OUT_W-1:0] dist_length;
      logic                 out_of_range;
   } rsp_type;

endpackage

@@ sv/ihau_ram.sv @@
module ihau_ram import ihau_pkg::*; #(
   parameter int DEPTH = NUM_BINS_DEF,
   parameter int WIDTH = TAG_W + COUNT_W
) (
   input  logic                     clock,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port, one registered read port; read returns old data on collision
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/integer_histogram_accumulator_unit.sv @@
// Histogram bin counter.
// Input channel req_*: one beat carries an op (count, read, clear) and a value.
// Result channel rsp_*: exactly one beat per input beat, in order, holding the
// addressed bin's count, the distribution length (saturated at 255) and an
// out-of-range flag.
// Throughput: one beat per cycle while req_stall is low. The bin store read is
// registered with the input, then the update and result are computed in one pass
// and loaded into the result register.
// Each bin word carries an epoch tag; a clear bumps the epoch, so a bin reads
// as empty unless its tag matches. Back-to-back updates of one bin are
// forwarded around the store.
// Reset: a sweep writes every bin word to tag zero, with req_stall high.
// The same sweep runs after every 255th clear, once the epoch wraps.
// Receiver stall: while rsp_stall holds a waiting result, the result register
// holds, the pipeline freezes and req_stall is raised.
module integer_histogram_accumulator_unit import ihau_pkg::*; #(
   parameter int NUM_BINS = NUM_BINS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int IDX_W  = $clog2(NUM_BINS);
   localparam int LEN_W  = $clog2(NUM_BINS + 1);
   localparam int WORD_W = TAG_W + COUNT_W;

   sweep_state_type state_ff, state_in;
   logic [IDX_W-1:0]  sweep_idx_ff, sweep_idx_in;
   logic [TAG_W-1:0]  epoch_ff, epoch_in;
   logic [LEN_W-1:0]  length_ff, length_in;

   logic              s1_valid_ff, s1_valid_in;
   logic [1:0]        s1_op_ff, s1_op_in;
   logic [IDX_W-1:0]  s1_idx_ff, s1_idx_in;
   logic              s1_in_range_ff, s1_in_range_in;

   logic              fwd_valid_ff, fwd_valid_in;
   logic [IDX_W-1:0]  fwd_idx_ff, fwd_idx_in;
   logic [WORD_W-1:0] fwd_word_ff, fwd_word_in;

   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   logic              sweeping, sweep_last, start_sweep;
   logic              advance, wrap_clear, req_accept, req_in_range, proc;
   logic              count_wr;
   logic [WORD_W-1:0] rd_word, cur_word, new_word, ram_wr_word;
   logic [IDX_W-1:0]  ram_wr_addr;
   logic              ram_wr_en;
   logic [COUNT_W-1:0] cur_count, inc_count;
   logic [LEN_W-1:0]  cand_len, len_after;
   rsp_type           result;

   // Sweep state: next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_SWEEP: if (sweep_last) state_in = ST_RUN;
         ST_RUN:   if (start_sweep) state_in = ST_SWEEP;
         default:  state_in = ST_SWEEP;
      endcase
   end

   // Sweep state: outputs
   always_comb begin
      sweeping     = (state_ff == ST_SWEEP);
      sweep_last   = sweeping && (sweep_idx_ff == IDX_W'(NUM_BINS - 1));
      sweep_idx_in = sweeping ? sweep_idx_ff + 1'b1 : '0;
   end

   // Handshake: freeze while a result waits, while the store is swept, or while an epoch-wrapping clear waits
   assign advance      = !rsp_valid_ff || !rsp_stall;
   assign wrap_clear   = s1_valid_ff && (s1_op_ff == OP_CLEAR) && (epoch_ff == '1);
   assign req_stall    = sweeping || !advance || wrap_clear;
   assign req_accept   = req_valid && !req_stall;
   assign req_in_range = !req_data.value[31] &&
                         ($unsigned(req_data.value) < 32'(NUM_BINS));
   assign proc         = s1_valid_ff && advance && !sweeping;

   // Current bin word, with the previous update forwarded
   assign cur_word  = (fwd_valid_ff && (fwd_idx_ff == s1_idx_ff)) ? fwd_word_ff : rd_word;
   assign cur_count = (cur_word[WORD_W-1 -: TAG_W] == epoch_ff) ? cur_word[COUNT_W-1:0] : '0;
   assign inc_count = (cur_count == COUNT_MAX) ? cur_count : cur_count + 1'b1;
   assign new_word  = {epoch_ff, inc_count};
   assign cand_len  = LEN_W'(s1_idx_ff) + LEN_W'(1);

   // Operation decode and result
   always_comb begin
      result       = '0;
      len_after    = length_ff;
      epoch_in     = epoch_ff;
      start_sweep  = 1'b0;
      count_wr     = 1'b0;
      if (proc) begin
         unique case (s1_op_ff)
            OP_COUNT: begin
               if (s1_in_range_ff) begin
                  count_wr         = 1'b1;
                  result.bin_count = inc_count;
                  if (cand_len > length_ff) len_after = cand_len;
               end else begin
                  result.out_of_range = 1'b1;
               end
            end
            OP_READ: begin
               if (s1_in_range_ff) result.bin_count = cur_count;
               else result.out_of_range = 1'b1;
            end
            OP_CLEAR: begin
               len_after = '0;
               if (epoch_ff == '1) begin
                  start_sweep = 1'b1;
                  epoch_in    = TAG_W'(1);
               end else begin
                  epoch_in = epoch_ff + 1'b1;
               end
            end
            default: ;
         endcase
      end
      result.dist_length = (32'(len_after) > 32'(LEN_OUT_MAX)) ? LEN_OUT_MAX
                                                               : LEN_OUT_W'(len_after);
      length_in = len_after;
   end

   // Pipeline register next values
   always_comb begin
      s1_valid_in     = s1_valid_ff;
      s1_op_in        = s1_op_ff;
      s1_idx_in       = s1_idx_ff;
      s1_in_range_in  = s1_in_range_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_data_in     = rsp_data_ff;
      if (advance) begin
         s1_valid_in  = req_accept;
         rsp_valid_in = proc;
      end
      if (req_accept) begin
         s1_op_in       = req_data.op;
         s1_idx_in      = req_data.value[IDX_W-1:0];
         s1_in_range_in = req_in_range;
      end
      if (proc) rsp_data_in = result;
   end

   // Forwarding register tracks the latest bin write
   always_comb begin
      fwd_valid_in = fwd_valid_ff;
      fwd_idx_in   = fwd_idx_ff;
      fwd_word_in  = fwd_word_ff;
      if (sweeping) begin
         fwd_valid_in = 1'b0;
      end else if (count_wr) begin
         fwd_valid_in = 1'b1;
         fwd_idx_in   = s1_idx_ff;
         fwd_word_in  = new_word;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SWEEP;
         sweep_idx_ff <= '0;
         epoch_ff     <= TAG_W'(1);
         length_ff    <= '0;
         s1_valid_ff  <= 1'b0;
         fwd_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_idx_ff <= sweep_idx_in;
         epoch_ff     <= epoch_in;
         length_ff    <= length_in;
         s1_valid_ff  <= s1_valid_in;
         fwd_valid_ff <= fwd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      s1_op_ff       <= s1_op_in;
      s1_idx_ff      <= s1_idx_in;
      s1_in_range_ff <= s1_in_range_in;
      fwd_idx_ff     <= fwd_idx_in;
      fwd_word_ff    <= fwd_word_in;
      rsp_data_ff    <= rsp_data_in;
   end

   // Bin store: sweep writes tag zero, which never matches a live epoch
   assign ram_wr_en   = sweeping || count_wr;
   assign ram_wr_addr = sweeping ? sweep_idx_ff : s1_idx_ff;
   assign ram_wr_word = sweeping ? '0 : new_word;

   ihau_ram #(
      .DEPTH (NUM_BINS),
      .WIDTH (WORD_W)
   ) u_bins (
      .clock   (clock),
      .rd_en   (req_accept),
      .rd_addr (req_data.value[IDX_W-1:0]),
      .rd_data (rd_word),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_word)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ sv/ihau_checker.sv @@
module ihau_checker import ihau_pkg::*; #(
   parameter int NUM_BINS = NUM_BINS_DEF
) (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // Store sweep holds off input right after reset
   assert property (@(posedge clock) $past(reset) |-> req_stall)
      else $error("input taken during reset sweep");

   // No result beat straight out of reset
   assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("result beat right after reset");

   // A stalled request beat holds
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_data))
      else $error("stalled request beat changed");

   // A stalled result beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result beat changed");

   // A flagged beat carries no count, and the length stays within the bins
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.out_of_range && (rsp_data.bin_count != '0)) &&
                    (32'(rsp_data.dist_length) <= 32'(NUM_BINS)))
      else $error("bad result fields");

endmodule

bind integer_histogram_accumulator_unit ihau_checker #(.NUM_BINS(NUM_BINS)) u_checker (.*);

@@ tb/hist_scoreboard_pkg.sv @@
package hist_scoreboard_pkg;

   import ihau_pkg::*;

   // Tracks the histogram as the block should see it and checks each result beat
   class hist_scoreboard;

      logic [COUNT_W-1:0] tally[NUM_BINS_DEF];
      bit                 tally_live[NUM_BINS_DEF];
      int unsigned        hist_length;
      rsp_type            results_due[$];

      int unsigned        mismatches;
      int unsigned        results_checked;
      int unsigned        n_count;
      int unsigned        n_read;
      int unsigned        n_clear;
      int unsigned        n_unused;
      int unsigned        n_flagged;
      logic [COUNT_W-1:0] peak_count;

      function new();
         foreach (tally[i]) begin
            tally[i]      = '0;
            tally_live[i] = 1'b0;
         end
         hist_length     = 0;
         mismatches      = 0;
         results_checked = 0;
         n_count         = 0;
         n_read          = 0;
         n_clear         = 0;
         n_unused        = 0;
         n_flagged       = 0;
         peak_count      = '0;
      endfunction

      // Apply one accepted request beat and queue the result it must produce
      function void take_request(req_type beat);
         logic [31:0] raw;
         bit          hit;
         rsp_type     want;
         raw  = beat.value;
         hit  = !raw[31] && (raw < NUM_BINS_DEF);
         want = '0;
         case (beat.op)
            OP_COUNT: begin
               n_count++;
               if (hit) begin
                  want.bin_count = tally_live[raw] ? tally[raw] : '0;
                  // saturate at the top of the count range
                  if (want.bin_count != COUNT_MAX) begin
                     want.bin_count = want.bin_count + 1'b1;
                  end
                  tally[raw]      = want.bin_count;
                  tally_live[raw] = 1'b1;
                  if (raw + 1 > hist_length) begin
                     hist_length = raw + 1;
                  end
                  if (want.bin_count > peak_count) begin
                     peak_count = want.bin_count;
                  end
               end else begin
                  want.out_of_range = 1'b1;
                  n_flagged++;
               end
            end
            OP_READ: begin
               n_read++;
               if (hit) begin
                  want.bin_count = tally_live[raw] ? tally[raw] : '0;
               end else begin
                  want.out_of_range = 1'b1;
                  n_flagged++;
               end
            end
            OP_CLEAR: begin
               n_clear++;
               foreach (tally_live[i]) begin
                  tally_live[i] = 1'b0;
               end
               hist_length = 0;
            end
            default: begin
               // unused op code: no state change
               n_unused++;
            end
         endcase
         want.dist_length = (hist_length > LEN_OUT_MAX) ? LEN_OUT_MAX
                                                        : hist_length[LEN_OUT_W-1:0];
         results_due.push_back(want);
      endfunction

      function void log_mismatch(string what);
         if (mismatches < 10) begin
            $display("mismatch: %s", what);
         end
         mismatches++;
      endfunction

      // Compare one accepted result beat against the oldest expectation
      function void check_result(rsp_type got);
         rsp_type want;
         results_checked++;
         if (results_due.size() == 0) begin
            log_mismatch($sformatf("result beat %h with nothing outstanding", got));
            return;
         end
         want = results_due.pop_front();
         if (got.bin_count !== want.bin_count) begin
            log_mismatch($sformatf("bin_count expected %0d got %0d",
                                   want.bin_count, got.bin_count));
         end
         if (got.dist_length !== want.dist_length) begin
            log_mismatch($sformatf("dist_length expected %0d got %0d",
                                   want.dist_length, got.dist_length));
         end
         if (got.out_of_range !== want.out_of_range) begin
            log_mismatch($sformatf("out_of_range expected %0b got %0b",
                                   want.out_of_range, got.out_of_range));
         end
      endfunction

      function void report_leftovers();
         foreach (results_due[i]) begin
            log_mismatch($sformatf("result %h never arrived", results_due[i]));
         end
         results_due.delete();
      endfunction

   endclass

endpackage

@@ tb/tb_top.sv @@
module tb_top;

   timeunit 1ns;
   timeprecision 1ps;

   import ihau_pkg::*;
   import hist_scoreboard_pkg::*;

   localparam logic [1:0] OP_UNUSED  = 2'd3;
   localparam int         IDLE_LIMIT = 4000;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   hist_scoreboard hist_sb;
   int unsigned    idle_cycles;
   bit             sender_burst;

   integer_histogram_accumulator_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Sender gaps: mostly none or short, a few long; none at all in burst stretches
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (sender_burst || r < 60) begin
         return 0;
      end else if (r < 88) begin
         return $urandom_range(1, 3);
      end else if (r < 97) begin
         return $urandom_range(4, 10);
      end
      return $urandom_range(20, 60);
   endfunction

   // Values lean on low bins so counts build up; edges and wild values mixed in
   function automatic logic [31:0] pick_value();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 50) begin
         return $urandom_range(0, 15);
      end else if (r < 70) begin
         return $urandom_range(0, NUM_BINS_DEF - 1);
      end else if (r < 78) begin
         return NUM_BINS_DEF - 2 + $urandom_range(0, 2);
      end else if (r < 85) begin
         return -$urandom_range(1, 4);
      end
      return $urandom;
   endfunction

   function automatic logic [1:0] pick_op(int unsigned clear_pct);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < clear_pct) begin
         return OP_CLEAR;
      end else if (r < clear_pct + 4) begin
         return OP_UNUSED;
      end else if ($urandom_range(0, 9) < 6) begin
         return OP_COUNT;
      end
      return OP_READ;
   endfunction

   // Drive one request beat and hold it until the block takes it
   task automatic send_op(logic [1:0] op, logic [31:0] value);
      req_type     beat;
      int unsigned gap;
      beat.op    = op;
      beat.value = value;
      gap        = pick_gap();
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= beat;
      do @(posedge clock); while (req_stall);
      hist_sb.take_request(beat);
   endtask

   task automatic run_random(int unsigned n_items, int unsigned clear_pct);
      for (int unsigned i = 0; i < n_items; i++) begin
         if (i % 64 == 0) begin
            sender_burst = ($urandom_range(0, 3) == 0);
         end
         send_op(pick_op(clear_pct), pick_value());
      end
   endtask

   // Sender holds off until every outstanding result has come back
   task automatic pause_until_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (hist_sb.results_due.size() != 0) @(posedge clock);
   endtask

   task automatic hold_rsp_stall(bit level, int unsigned n_cycles);
      repeat (n_cycles) begin
         @(negedge clock);
         rsp_stall <= level;
      end
   endtask

   // Receiver: bursts of stall, mostly short, with occasional long free runs
   initial begin
      rsp_stall = 1'b0;
      forever begin
         if ($urandom_range(0, 99) < 12) begin
            hold_rsp_stall(1'b0, $urandom_range(100, 300));
         end else begin
            hold_rsp_stall(1'b1, ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                              : $urandom_range(0, 3));
            hold_rsp_stall(1'b0, $urandom_range(1, 6));
         end
      end
   end

   // Result beats
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         hist_sb.check_result(rsp_data);
      end
   end

   // Watchdog on cycles with no beat on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL integer_histogram_accumulator_unit");
            $finish;
         end
      end
   end

   initial begin
      hist_sb      = new();
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_data     = '0;
      sender_burst = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: empty reads, same-bin back to back, edge bins, bad values, clears
      send_op(OP_READ, 0);
      send_op(OP_COUNT, 0);
      send_op(OP_COUNT, 0);
      send_op(OP_READ, 0);
      send_op(OP_COUNT, NUM_BINS_DEF - 1);
      send_op(OP_READ, NUM_BINS_DEF - 1);
      send_op(OP_COUNT, NUM_BINS_DEF);
      send_op(OP_COUNT, 32'hFFFF_FFFF);
      send_op(OP_COUNT, 32'h8000_0000);
      send_op(OP_COUNT, 32'h7FFF_FFFF);
      send_op(OP_READ, NUM_BINS_DEF);
      send_op(OP_READ, 32'h8000_0000);
      send_op(OP_UNUSED, 5);
      send_op(OP_COUNT, 5);
      send_op(OP_COUNT, 5);
      send_op(OP_READ, 5);
      send_op(OP_READ, 6);
      send_op(OP_CLEAR, 0);
      send_op(OP_READ, 5);
      send_op(OP_READ, NUM_BINS_DEF - 1);
      send_op(OP_COUNT, 3);
      send_op(OP_READ, 3);
      send_op(OP_CLEAR, 32'hFFFF_FFFF);
      send_op(OP_CLEAR, 0);
      send_op(OP_COUNT, NUM_BINS_DEF - 2);
      pause_until_drained();

      // Count-heavy traffic builds real distributions
      run_random(600, 2);
      pause_until_drained();

      // Clear-heavy traffic walks the clear epoch past its wrap
      run_random(400, 70);
      pause_until_drained();

      repeat (20) @(posedge clock);
      hist_sb.report_leftovers();
      $display("Covered %0d count, %0d read, %0d clear, %0d unused-op beats, %0d out of range",
               hist_sb.n_count, hist_sb.n_read, hist_sb.n_clear, hist_sb.n_unused,
               hist_sb.n_flagged);
      $display("Checked %0d result beats, highest bin count %0d, %0d mismatches",
               hist_sb.results_checked, hist_sb.peak_count, hist_sb.mismatches);
      if (hist_sb.mismatches == 0) begin
         $display("PASS integer_histogram_accumulator_unit");
      end else begin
         $display("FAIL integer_histogram_accumulator_unit");
      end
      $finish;
   end

endmodule
